### sv/ping_pkg.sv
// ----------------------------------------------------------------------------
// ping_pkg
// Shared types and constants for the pairwise identity neighbor graph core.
// ----------------------------------------------------------------------------
package ping_pkg;

  localparam int DEF_MAX_SEQS = 64;
  localparam int DEF_MAX_LEN  = 1024;

  localparam int RES_W  = 8;
  localparam int CNT_W  = 11;
  localparam int SEQ_W  = 6;
  localparam int MASK_W = 64;
  localparam int POS_W  = 16;   // covers positions below the largest MAX_LEN
  localparam int LEN_W  = 17;   // covers lengths up to the largest MAX_LEN

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // APB register map
  localparam int   ADDR_W       = 3;
  localparam int   DATA_W       = 32;
  localparam logic REG_MAX_MISM = 1'b0;

  // One item as it travels down the cell chain
  typedef struct packed {
    logic              vld;
    logic [RES_W-1:0]  res;
    logic [POS_W-1:0]  pos;
    logic              store;   // residue lands in the store of cell seq
    logic [SEQ_W-1:0]  seq;
    logic              full;    // sequence beyond capacity
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  len;     // position count after this residue
    logic [MASK_W-1:0] mask;
  } tok_t;

endpackage

### sv/pairwise_identity_neighbor_graph_core.sv
// ----------------------------------------------------------------------------
// pairwise_identity_neighbor_graph_core
// Hamming-distance threshold neighbor graph over a streamed alignment.
// ----------------------------------------------------------------------------
// Usage:
//   Residues enter on the in_ channel, one item per residue, with flags for
//   the start of an alignment and the end of a sequence. Every item whose
//   last_of_sequence is set yields one result item on the out_ channel: the
//   index of the finished sequence and a mask of the earlier sequences whose
//   mismatch count is at most max_mismatches (APB register at address 0).
//   Sequences past MAX_SEQS are not stored and report overflow with a zero
//   mask and index 0.
//   The block is a chain of MAX_SEQS cells, one per stored sequence, each
//   with its own residue row; an item walks the chain at two register stages
//   per cell, and a result leaves through an output register after the last
//   cell. One item is accepted per cycle while the output is not stalled.
//   When out_ready is low with a result waiting, the whole chain holds and
//   in_ready drops until the result is taken. Reset empties the chain,
//   clears the sequence and position counters and sets max_mismatches to 0;
//   no clearing pass is needed, items are accepted right away.
// ----------------------------------------------------------------------------
module pairwise_identity_neighbor_graph_core #(
  parameter int MAX_SEQS = ping_pkg::DEF_MAX_SEQS,
  parameter int MAX_LEN  = ping_pkg::DEF_MAX_LEN
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ping_pkg::RES_W-1:0]  in_residue,
  input  logic                        in_first_of_alignment,
  input  logic                        in_last_of_sequence,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ping_pkg::SEQ_W-1:0]  out_sequence_index,
  output logic [ping_pkg::MASK_W-1:0] out_neighbor_mask,
  output logic                        out_overflow,

  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ping_pkg::ADDR_W-1:0] paddr,
  input  logic [ping_pkg::DATA_W-1:0] pwdata,
  output logic [ping_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import ping_pkg::*;

  logic             adv, take;
  logic [CNT_W-1:0] max_mism_r;
  tok_t             chain [MAX_SEQS+1];
  tok_t             tail;

  logic              out_valid_r;
  logic [SEQ_W-1:0]  out_seq_r;
  logic [MASK_W-1:0] out_mask_r;
  logic              out_ovf_r;

  // global advance: the chain only moves when the output slot can take it
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign take     = in_valid && adv;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_MISM) ? DATA_W'(max_mism_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mism_r <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_MISM)) begin
      max_mism_r <= pwdata[CNT_W-1:0];
    end
  end

  ping_feed #(
    .MAX_SEQS (MAX_SEQS),
    .MAX_LEN  (MAX_LEN)
  ) u_feed (
    .clk                (clk),
    .rst_n              (rst_n),
    .take               (take),
    .residue            (in_residue),
    .first_of_alignment (in_first_of_alignment),
    .last_of_sequence   (in_last_of_sequence),
    .tok                (chain[0])
  );

  for (genvar k = 0; k < MAX_SEQS; k++) begin : g_cell
    ping_cell #(
      .IDX     (k),
      .MAX_LEN (MAX_LEN)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .max_mism (max_mism_r),
      .tok_in   (chain[k]),
      .tok_out  (chain[k+1])
    );
  end

  assign tail = chain[MAX_SEQS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tail.vld && tail.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_seq_r  <= tail.full ? '0 : tail.seq;
      out_mask_r <= tail.full ? '0 : tail.mask;
      out_ovf_r  <= tail.full;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sequence_index = out_seq_r;
  assign out_neighbor_mask  = out_mask_r;
  assign out_overflow       = out_ovf_r;

endmodule

### sv/ping_feed.sv
// ----------------------------------------------------------------------------
// ping_feed
// Tracks sequence number and position, and turns each input item into a
// token for the head of the cell chain.
// ----------------------------------------------------------------------------
module ping_feed #(
  parameter int MAX_SEQS = ping_pkg::DEF_MAX_SEQS,
  parameter int MAX_LEN  = ping_pkg::DEF_MAX_LEN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       take,
  input  logic [ping_pkg::RES_W-1:0] residue,
  input  logic                       first_of_alignment,
  input  logic                       last_of_sequence,
  output ping_pkg::tok_t             tok
);
  import ping_pkg::*;

  localparam int SCW = $clog2(MAX_SEQS + 1);
  localparam int LW  = $clog2(MAX_LEN + 1);

  logic [SCW-1:0] seq_r, seq_nxt, eff_seq;
  logic [LW-1:0]  pos_r, pos_nxt, eff_pos, pos_after;
  logic           full, store;

  always_comb begin
    eff_seq   = first_of_alignment ? '0 : seq_r;
    eff_pos   = first_of_alignment ? '0 : pos_r;
    full      = (eff_seq >= SCW'(MAX_SEQS));
    store     = !full && (eff_pos < LW'(MAX_LEN));
    pos_after = store ? eff_pos + LW'(1) : eff_pos;

    if (last_of_sequence) begin
      pos_nxt = '0;
      seq_nxt = full ? eff_seq : eff_seq + SCW'(1);
    end else begin
      pos_nxt = pos_after;
      seq_nxt = eff_seq;
    end

    tok       = '0;
    tok.vld   = take;
    tok.res   = residue;
    tok.pos   = POS_W'(eff_pos);
    tok.store = store;
    tok.seq   = SEQ_W'(eff_seq);
    tok.full  = full;
    tok.first = first_of_alignment;
    tok.last  = last_of_sequence;
    tok.len   = LEN_W'(pos_after);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
      pos_r <= '0;
    end else if (take) begin
      seq_r <= seq_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

### sv/ping_cell.sv
// ----------------------------------------------------------------------------
// ping_cell
// One stored sequence: its residue row, its length and its mismatch counter
// against the sequence streaming in. Two register stages per cell; the
// token moves one stage each advancing cycle.
// ----------------------------------------------------------------------------
module ping_cell #(
  parameter int IDX     = 0,
  parameter int MAX_LEN = ping_pkg::DEF_MAX_LEN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic [ping_pkg::CNT_W-1:0] max_mism,
  input  ping_pkg::tok_t             tok_in,
  output ping_pkg::tok_t             tok_out
);
  import ping_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int EW = ((LW > CNT_W) ? LW : CNT_W) + 1;

  logic [RES_W-1:0] mem [MAX_LEN];

  logic [AW-1:0]    addr;
  logic [LW-1:0]    len_in, extra_in;
  logic             own, older, beyond;

  tok_t             tka_r, tkb_r, tok_b;
  logic [RES_W-1:0] rd_r;
  logic             older_r, beyond_r;
  logic [LW-1:0]    extra_r, slen_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, base, cnt_inc, tot;
  logic [EW-1:0]    sum;
  logic             hit, near;

  // stage A: decode against this cell, access the residue row
  always_comb begin
    addr     = tok_in.pos[AW-1:0];
    len_in   = tok_in.len[LW-1:0];
    own      = !tok_in.full && (tok_in.seq == SEQ_W'(IDX));
    older    = !tok_in.full && (SEQ_W'(IDX) < tok_in.seq);
    beyond   = (LEN_W'(tok_in.pos) >= LEN_W'(slen_r));
    extra_in = (slen_r > len_in) ? slen_r - len_in : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (tok_in.vld && own && tok_in.store) begin
        mem[addr] <= tok_in.res;
      end
      rd_r <= mem[addr];
    end
  end

  // length lives in stage A so the next token already sees it
  always_ff @(posedge clk) begin
    if (adv) begin
      if (tok_in.vld && own && tok_in.last) begin
        slen_r <= len_in;
      end
      older_r  <= older;
      beyond_r <= beyond;
      extra_r  <= extra_in;
    end
  end

  // stage B: count, and on the last residue test against the limit
  always_comb begin
    base    = tka_r.first ? '0 : cnt_r;
    hit     = tka_r.store && older_r && (beyond_r || (rd_r != tka_r.res));
    cnt_inc = (hit && (base != CNT_MAX)) ? base + CNT_W'(1) : base;
    sum     = EW'(cnt_inc) + EW'(extra_r);
    tot     = (sum > EW'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];
    near    = (tot <= max_mism);

    if (tka_r.vld) begin
      cnt_nxt = tka_r.last ? '0 : cnt_inc;
    end else begin
      cnt_nxt = cnt_r;
    end

    tok_b = tka_r;
    if (tka_r.last && older_r && near) begin
      tok_b.mask[IDX] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tka_r <= '0;
      tkb_r <= '0;
      cnt_r <= '0;
    end else if (adv) begin
      tka_r <= tok_in;
      tkb_r <= tok_b;
      cnt_r <= cnt_nxt;
    end
  end

  assign tok_out = tkb_r;

endmodule
